>>> rtl/culw_pkg.sv
// Package for the unstable log window: sizes, request codes, status codes
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package culw_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int MAX_EMIT     = 32;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  // request codes
  localparam logic [2:0] REQ_APPEND  = 3'd0;
  localparam logic [2:0] REQ_QUERY   = 3'd1;
  localparam logic [2:0] REQ_STABLE  = 3'd2;
  localparam logic [2:0] REQ_SNAP_OK = 3'd3;
  localparam logic [2:0] REQ_RESTORE = 3'd4;
  localparam logic [2:0] REQ_ACCEPT  = 3'd5;
  localparam logic [2:0] REQ_NEXT    = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISSING  = 3'd1;
  localparam logic [2:0] ST_SNAP     = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_NONE     = 3'd5;
  localparam logic [2:0] ST_GAP      = 3'd6;

  typedef struct packed {
    logic load;   // capture request
    logic look;   // issue memory read, set up emit run
    logic exec;   // apply single-result request
    logic emit;   // emit one entry of a run
  } cmd_t;

  typedef struct packed {
    logic is_next;    // captured request is next entries
    logic pending;    // entries wait after the progress mark
    logic emit_last;  // current emit is the final one
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/culw_ctl.sv
// Controller of the unstable log window: sequences load, lookup, execute
// and emit steps. Depends on culw_pkg.
`default_nettype none
module culw_ctl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire culw_pkg::stat_t stat,
  output culw_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (stat.is_next && stat.pending) state_nxt = S_EMIT;
        else state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/culw_dp.sv
// Datapath of the unstable log window: window state, snapshot, entry ring
// memory and result register. Depends on culw_pkg.
`default_nettype none
module culw_dp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire culw_pkg::cmd_t cmd,
  output culw_pkg::stat_t  stat,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [63:0] in_entry_index,
  input  wire logic [63:0] in_entry_term,
  input  wire logic [31:0] in_entry_handle,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic             out_found,
  output logic [63:0]      out_index,
  output logic [63:0]      out_term,
  output logic [31:0]      out_handle,
  output logic             out_last_of_run,
  output logic [63:0]      out_last_index,
  output logic             out_last_valid,
  output logic [63:0]      out_first_index,
  output logic             out_first_valid,
  output logic             out_snapshot_pending
);

  localparam int SW = culw_pkg::SLOT_W;
  localparam int CW = culw_pkg::CNT_W;

  // captured request
  logic [2:0]  req_type_r;
  logic [63:0] req_index_r, req_term_r;
  logic [31:0] req_handle_r;

  // window and snapshot state
  logic [63:0]   ws_r, ws_nxt, pm_r, pm_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          snap_held_r, snap_held_nxt, snap_acc_r, snap_acc_nxt;
  logic [63:0]   snap_index_r, snap_index_nxt, snap_term_r, snap_term_nxt;

  // ring memory
  logic [63:0]   term_mem [culw_pkg::WINDOW_DEPTH];
  logic [31:0]   handle_mem [culw_pkg::WINDOW_DEPTH];
  logic [63:0]   rd_term_r;
  logic [31:0]   rd_handle_r;
  logic [SW-1:0] rd_addr;
  logic          wr_en;

  // emit run
  logic [63:0]   emit_idx_r;
  logic [CW-1:0] emit_left_r, emit_n;

  // result register
  logic          ov_r;
  logic [2:0]    st_r, st_nxt;
  logic          found_r, found_nxt, last_r;
  logic [63:0]   oidx_r, oidx_nxt, oterm_r, oterm_nxt;
  logic [31:0]   ohdl_r;

  logic [63:0] diff, pm_diff, idx_p1, ws_plus_cnt;
  logic        ge, in_win, pend;

  assign diff        = req_index_r - ws_r;
  assign ge          = (req_index_r >= ws_r);
  assign in_win      = ge && (diff < 64'(cnt_r));
  assign pm_diff     = pm_r - ws_r;
  assign pend        = (pm_r >= ws_r) && (pm_diff < 64'(cnt_r));
  assign idx_p1      = req_index_r + 64'd1;
  assign ws_plus_cnt = ws_r + 64'(cnt_r);

  // run length, clamped to the emit limit
  always_comb begin
    emit_n = cnt_r - pm_diff[CW-1:0];
    if (32'(emit_n) > culw_pkg::MAX_EMIT) emit_n = CW'(culw_pkg::MAX_EMIT);
  end

  assign stat.is_next   = (req_type_r == culw_pkg::REQ_NEXT);
  assign stat.pending   = pend;
  assign stat.emit_last = (emit_left_r == CW'(1));

  // choose read slot: request index, progress mark, or next emitted entry
  always_comb begin
    if (cmd.emit) rd_addr = SW'(emit_idx_r + 64'd1);
    else if (req_type_r == culw_pkg::REQ_NEXT) rd_addr = pm_r[SW-1:0];
    else rd_addr = req_index_r[SW-1:0];
  end

  // apply a single-result request
  always_comb begin
    ws_nxt         = ws_r;
    pm_nxt         = pm_r;
    cnt_nxt        = cnt_r;
    snap_held_nxt  = snap_held_r;
    snap_acc_nxt   = snap_acc_r;
    snap_index_nxt = snap_index_r;
    snap_term_nxt  = snap_term_r;
    wr_en          = 1'b0;
    st_nxt         = culw_pkg::ST_OK;
    found_nxt      = 1'b0;
    oidx_nxt       = req_index_r;
    oterm_nxt      = '0;
    case (req_type_r)
      culw_pkg::REQ_APPEND: begin
        if (ge && diff == 64'(cnt_r)) begin
          if (32'(cnt_r) >= culw_pkg::WINDOW_DEPTH) begin
            st_nxt = culw_pkg::ST_FULL;
          end else begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end else if (req_index_r <= ws_r) begin
          ws_nxt  = req_index_r;
          pm_nxt  = req_index_r;
          cnt_nxt = CW'(1);
          wr_en   = 1'b1;
        end else if (in_win) begin
          cnt_nxt = diff[CW-1:0] + CW'(1);
          wr_en   = 1'b1;
          if (req_index_r < pm_r) pm_nxt = req_index_r;
        end else begin
          st_nxt = culw_pkg::ST_GAP;
        end
      end
      culw_pkg::REQ_QUERY: begin
        if (!ge) begin
          if (snap_held_r && snap_index_r == req_index_r) begin
            found_nxt = 1'b1;
            oterm_nxt = snap_term_r;
          end else begin
            st_nxt = culw_pkg::ST_MISSING;
          end
        end else if (in_win) begin
          found_nxt = 1'b1;
          oterm_nxt = rd_term_r;
        end else begin
          st_nxt = culw_pkg::ST_MISSING;
        end
      end
      culw_pkg::REQ_STABLE: begin
        if (!ge) begin
          if (snap_held_r && snap_index_r == req_index_r) begin
            st_nxt    = culw_pkg::ST_SNAP;
            found_nxt = 1'b1;
            oterm_nxt = snap_term_r;
          end else begin
            st_nxt = culw_pkg::ST_MISSING;
          end
        end else if (in_win) begin
          found_nxt = 1'b1;
          oterm_nxt = rd_term_r;
          if (rd_term_r != req_term_r) begin
            st_nxt = culw_pkg::ST_MISMATCH;
          end else begin
            cnt_nxt = cnt_r - diff[CW-1:0] - CW'(1);
            ws_nxt  = idx_p1;
            if (pm_r < idx_p1) pm_nxt = idx_p1;
          end
        end else begin
          st_nxt = culw_pkg::ST_MISSING;
        end
      end
      culw_pkg::REQ_SNAP_OK: begin
        if (snap_held_r && snap_index_r == req_index_r) begin
          snap_held_nxt = 1'b0;
          snap_acc_nxt  = 1'b0;
        end else begin
          st_nxt = culw_pkg::ST_MISSING;
        end
      end
      culw_pkg::REQ_RESTORE: begin
        ws_nxt         = idx_p1;
        pm_nxt         = idx_p1;
        cnt_nxt        = '0;
        snap_held_nxt  = 1'b1;
        snap_acc_nxt   = 1'b0;
        snap_index_nxt = req_index_r;
        snap_term_nxt  = req_term_r;
      end
      culw_pkg::REQ_ACCEPT: begin
        oidx_nxt = '0;
        if (cnt_r != '0) pm_nxt = ws_plus_cnt;
        if (snap_held_r) snap_acc_nxt = 1'b1;
      end
      culw_pkg::REQ_NEXT: begin
        // only reached with nothing pending
        st_nxt   = culw_pkg::ST_NONE;
        oidx_nxt = '0;
      end
      default: ;
    endcase
  end

  // capture request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r   <= in_req_type;
      req_index_r  <= in_entry_index;
      req_term_r   <= in_entry_term;
      req_handle_r <= in_entry_handle;
    end
  end

  // ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      term_mem[req_index_r[SW-1:0]]   <= req_term_r;
      handle_mem[req_index_r[SW-1:0]] <= req_handle_r;
    end
    rd_term_r   <= term_mem[rd_addr];
    rd_handle_r <= handle_mem[rd_addr];
  end

  // window and snapshot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r         <= '0;
      pm_r         <= '0;
      cnt_r        <= '0;
      snap_held_r  <= 1'b0;
      snap_acc_r   <= 1'b0;
      snap_index_r <= '0;
      snap_term_r  <= '0;
    end else if (cmd.exec) begin
      ws_r         <= ws_nxt;
      pm_r         <= pm_nxt;
      cnt_r        <= cnt_nxt;
      snap_held_r  <= snap_held_nxt;
      snap_acc_r   <= snap_acc_nxt;
      snap_index_r <= snap_index_nxt;
      snap_term_r  <= snap_term_nxt;
    end
  end

  // emit run pointer
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      emit_idx_r  <= pm_r;
      emit_left_r <= emit_n;
    end else if (cmd.emit) begin
      emit_idx_r  <= emit_idx_r + 64'd1;
      emit_left_r <= emit_left_r - CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= cmd.exec || cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      st_r    <= culw_pkg::ST_OK;
      found_r <= 1'b0;
      oidx_r  <= emit_idx_r;
      oterm_r <= rd_term_r;
      ohdl_r  <= rd_handle_r;
      last_r  <= (emit_left_r == CW'(1));
    end else if (cmd.exec) begin
      st_r    <= st_nxt;
      found_r <= found_nxt;
      oidx_r  <= oidx_nxt;
      oterm_r <= oterm_nxt;
      ohdl_r  <= '0;
      last_r  <= 1'b1;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_found       = found_r;
  assign out_index       = oidx_r;
  assign out_term        = oterm_r;
  assign out_handle      = ohdl_r;
  assign out_last_of_run = last_r;

  // bounds follow the state, which is already updated when the result shows
  always_comb begin
    if (cnt_r != '0) begin
      out_last_index = ws_plus_cnt - 64'd1;
      out_last_valid = 1'b1;
    end else if (snap_held_r) begin
      out_last_index = snap_index_r;
      out_last_valid = 1'b1;
    end else begin
      out_last_index = '0;
      out_last_valid = 1'b0;
    end
  end

  assign out_first_index      = snap_held_r ? snap_index_r + 64'd1 : 64'd0;
  assign out_first_valid      = snap_held_r;
  assign out_snapshot_pending = snap_held_r && !snap_acc_r;

endmodule
`default_nettype wire

>>> rtl/consensus_unstable_log_window.sv
// Unstable consensus-log window: a request raised on start while busy is low
// is taken; a single-result request passes lookup and execute, and busy falls
// as its result shows on out_valid. Next entries with entries pending passes
// load and lookup, then gives one result per cycle, one per pending entry up to
// MAX_EMIT, the last one flagged by out_last_of_run; the single read port of
// the entry ring sets the rate. Each result is shown for exactly one cycle
// and the receiver cannot stall. Depends on culw_pkg, culw_ctl and culw_dp.
`default_nettype none
module consensus_unstable_log_window (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [63:0] in_entry_index,
  input  wire logic [63:0] in_entry_term,
  input  wire logic [31:0] in_entry_handle,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic             out_found,
  output logic [63:0]      out_index,
  output logic [63:0]      out_term,
  output logic [31:0]      out_handle,
  output logic             out_last_of_run,
  output logic [63:0]      out_last_index,
  output logic             out_last_valid,
  output logic [63:0]      out_first_index,
  output logic             out_first_valid,
  output logic             out_snapshot_pending
);

  culw_pkg::cmd_t  cmd;
  culw_pkg::stat_t stat;

  culw_ctl u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  culw_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_req_type          (in_req_type),
    .in_entry_index       (in_entry_index),
    .in_entry_term        (in_entry_term),
    .in_entry_handle      (in_entry_handle),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_found            (out_found),
    .out_index            (out_index),
    .out_term             (out_term),
    .out_handle           (out_handle),
    .out_last_of_run      (out_last_of_run),
    .out_last_index       (out_last_index),
    .out_last_valid       (out_last_valid),
    .out_first_index      (out_first_index),
    .out_first_valid      (out_first_valid),
    .out_snapshot_pending (out_snapshot_pending)
  );

endmodule
`default_nettype wire

>>> bench/tb.sv
// Testbench for consensus_unstable_log_window: drives log-window requests and
// checks every emitted result against an in-bench model of the window.
// Depends on culw_pkg and the RTL top level.
`default_nettype none
module tb;

  // selector outside the defined request set
  localparam logic [2:0] REQ_UNDEF = 3'd7;

  typedef struct {
    logic [2:0]  status;
    logic        found;
    logic [63:0] idx;
    logic [63:0] term;
    logic [31:0] handle;
    logic        last_run;
    logic [63:0] last_index;
    logic        last_valid;
    logic [63:0] first_index;
    logic        first_valid;
    logic        snap_pend;
  } log_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_req_type;
  logic [63:0] in_entry_index;
  logic [63:0] in_entry_term;
  logic [31:0] in_entry_handle;
  logic        out_valid;
  logic [2:0]  out_status;
  logic        out_found;
  logic [63:0] out_index;
  logic [63:0] out_term;
  logic [31:0] out_handle;
  logic        out_last_of_run;
  logic [63:0] out_last_index;
  logic        out_last_valid;
  logic [63:0] out_first_index;
  logic        out_first_valid;
  logic        out_snapshot_pending;

  consensus_unstable_log_window uut (.*);

  // window model state
  logic [63:0] win_start;
  logic [63:0] prog_mark;
  int unsigned win_count;
  logic        snap_held;
  logic [63:0] snap_idx;
  logic [63:0] snap_trm;
  logic        snap_acc;
  logic [63:0] term_ring [culw_pkg::WINDOW_DEPTH];
  logic [31:0] handle_ring [culw_pkg::WINDOW_DEPTH];

  log_result_t expected_results[$];
  int          fail_count = 0;
  longint      cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic log_result_t make_result(logic [2:0] st, logic fnd,
      logic [63:0] ix, logic [63:0] tm, logic [31:0] hd, logic lst);
    log_result_t r;
    r.status = st; r.found = fnd; r.idx = ix; r.term = tm; r.handle = hd;
    r.last_run = lst;
    if (win_count > 0) begin
      r.last_index = win_start + 64'(win_count) - 64'd1;
      r.last_valid = 1'b1;
    end else if (snap_held) begin
      r.last_index = snap_idx;
      r.last_valid = 1'b1;
    end else begin
      r.last_index = '0;
      r.last_valid = 1'b0;
    end
    r.first_index = snap_held ? snap_idx + 64'd1 : 64'd0;
    r.first_valid = snap_held;
    r.snap_pend   = snap_held && !snap_acc;
    return r;
  endfunction

  // Add one expectation at the tail of the queue.
  function automatic void queue_result(log_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Look up a term: 0 not found, 1 in snapshot, 2 in window.
  function automatic int lookup_term(logic [63:0] ix, output logic [63:0] tm);
    tm = '0;
    if (ix < win_start) begin
      if (snap_held && snap_idx == ix) begin
        tm = snap_trm;
        return 1;
      end
      return 0;
    end
    if (ix - win_start >= 64'(win_count)) return 0;
    tm = term_ring[ix % culw_pkg::WINDOW_DEPTH];
    return 2;
  endfunction

  // Apply one request to the model and queue its results.
  task automatic predict_log_op(logic [2:0] op, logic [63:0] ix, logic [63:0] tm,
      logic [31:0] hd);
    logic [63:0] t;
    int where;
    longint unsigned off, n;
    case (op)
      culw_pkg::REQ_APPEND: begin
        if (ix >= win_start && ix - win_start == 64'(win_count)) begin
          if (win_count >= culw_pkg::WINDOW_DEPTH) begin
            queue_result(make_result(culw_pkg::ST_FULL, 0, ix, 0, 0, 1));
            return;
          end
          term_ring[ix % culw_pkg::WINDOW_DEPTH] = tm;
          handle_ring[ix % culw_pkg::WINDOW_DEPTH] = hd;
          win_count++;
        end else if (ix <= win_start) begin
          win_start = ix; prog_mark = ix; win_count = 1;
          term_ring[ix % culw_pkg::WINDOW_DEPTH] = tm;
          handle_ring[ix % culw_pkg::WINDOW_DEPTH] = hd;
        end else if (ix - win_start < 64'(win_count)) begin
          win_count = int'(ix - win_start) + 1;
          term_ring[ix % culw_pkg::WINDOW_DEPTH] = tm;
          handle_ring[ix % culw_pkg::WINDOW_DEPTH] = hd;
          if (ix < prog_mark) prog_mark = ix;
        end else begin
          queue_result(make_result(culw_pkg::ST_GAP, 0, ix, 0, 0, 1));
          return;
        end
        queue_result(make_result(culw_pkg::ST_OK, 0, ix, 0, 0, 1));
      end
      culw_pkg::REQ_QUERY: begin
        where = lookup_term(ix, t);
        queue_result(make_result(where != 0 ? culw_pkg::ST_OK : culw_pkg::ST_MISSING,
                                 where != 0, ix, t, 0, 1));
      end
      culw_pkg::REQ_STABLE: begin
        where = lookup_term(ix, t);
        if (where == 0)
          queue_result(make_result(culw_pkg::ST_MISSING, 0, ix, 0, 0, 1));
        else if (where == 1)
          queue_result(make_result(culw_pkg::ST_SNAP, 1, ix, t, 0, 1));
        else if (t != tm)
          queue_result(make_result(culw_pkg::ST_MISMATCH, 1, ix, t, 0, 1));
        else begin
          win_count -= int'(ix - win_start) + 1;
          win_start = ix + 64'd1;
          if (prog_mark < win_start) prog_mark = win_start;
          queue_result(make_result(culw_pkg::ST_OK, 1, ix, t, 0, 1));
        end
      end
      culw_pkg::REQ_SNAP_OK: begin
        if (snap_held && snap_idx == ix) begin
          snap_held = 0; snap_acc = 0;
          queue_result(make_result(culw_pkg::ST_OK, 0, ix, 0, 0, 1));
        end else begin
          queue_result(make_result(culw_pkg::ST_MISSING, 0, ix, 0, 0, 1));
        end
      end
      culw_pkg::REQ_RESTORE: begin
        win_start = ix + 64'd1; prog_mark = win_start; win_count = 0;
        snap_held = 1; snap_idx = ix; snap_trm = tm; snap_acc = 0;
        queue_result(make_result(culw_pkg::ST_OK, 0, ix, 0, 0, 1));
      end
      culw_pkg::REQ_ACCEPT: begin
        if (win_count > 0) prog_mark = win_start + 64'(win_count);
        if (snap_held) snap_acc = 1;
        queue_result(make_result(culw_pkg::ST_OK, 0, 0, 0, 0, 1));
      end
      culw_pkg::REQ_NEXT: begin
        if (prog_mark < win_start || prog_mark - win_start >= 64'(win_count)) begin
          queue_result(make_result(culw_pkg::ST_NONE, 0, 0, 0, 0, 1));
        end else begin
          off = prog_mark - win_start;
          n = win_count - off;
          if (n > culw_pkg::MAX_EMIT) n = culw_pkg::MAX_EMIT;
          for (longint unsigned k = 0; k < n; k++)
            queue_result(make_result(culw_pkg::ST_OK, 0, prog_mark + k,
                term_ring[(prog_mark + k) % culw_pkg::WINDOW_DEPTH],
                handle_ring[(prog_mark + k) % culw_pkg::WINDOW_DEPTH], k + 1 == n));
        end
      end
      default: queue_result(make_result(culw_pkg::ST_OK, 0, ix, 0, 0, 1));
    endcase
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    log_result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d index=%h", $time, out_status,
                 out_index);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status || out_found !== e.found ||
            out_index !== e.idx || out_term !== e.term ||
            out_handle !== e.handle || out_last_of_run !== e.last_run ||
            out_last_index !== e.last_index || out_last_valid !== e.last_valid ||
            out_first_index !== e.first_index ||
            out_first_valid !== e.first_valid ||
            out_snapshot_pending !== e.snap_pend) begin
          $display("%0t: mismatch exp st=%0d f=%b ix=%h t=%h h=%h l=%b", $time,
                   e.status, e.found, e.idx, e.term, e.handle, e.last_run,
                   " li=%h lv=%b fi=%h fv=%b sp=%b", e.last_index, e.last_valid,
                   e.first_index, e.first_valid, e.snap_pend);
          $display("%0t:          got st=%0d f=%b ix=%h t=%h h=%h l=%b", $time,
                   out_status, out_found, out_index, out_term, out_handle,
                   out_last_of_run, " li=%h lv=%b fi=%h fv=%b sp=%b",
                   out_last_index, out_last_valid, out_first_index,
                   out_first_valid, out_snapshot_pending);
          fail_count++;
        end
      end
    end
  end

  // Send one request, holding start until busy falls, then sometimes idle a while.
  task automatic send_request(logic [2:0] op, logic [63:0] ix, logic [63:0] tm,
      logic [31:0] hd, bit with_gap = 1);
    int gap;
    start <= 1'b1;
    in_req_type <= op; in_entry_index <= ix; in_entry_term <= tm;
    in_entry_handle <= hd;
    do @(posedge clk); while (busy);
    predict_log_op(op, ix, tm, hd);
    if (with_gap && $urandom_range(0, 2) != 0) begin
      start <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Directed: extremes of fields, every request and every status but full.
  task automatic test_directed();
    logic [63:0] top;
    top = '1;
    send_request(culw_pkg::REQ_NEXT, 0, 0, 0);
    send_request(culw_pkg::REQ_QUERY, 0, 0, 0);
    send_request(culw_pkg::REQ_APPEND, 0, 64'd5, 32'hFFFF_FFFF);
    send_request(culw_pkg::REQ_APPEND, 1, top, 32'h0);
    send_request(culw_pkg::REQ_APPEND, 5, 1, 1);              // gap
    send_request(culw_pkg::REQ_QUERY, 1, 0, 0);
    send_request(culw_pkg::REQ_STABLE, 1, 64'd3, 0);          // term mismatch
    send_request(culw_pkg::REQ_STABLE, 0, 64'd5, 0);          // ok
    send_request(culw_pkg::REQ_NEXT, 0, 0, 0);
    send_request(culw_pkg::REQ_APPEND, 1, 64'd9, 32'h1234);   // truncate inside window
    send_request(culw_pkg::REQ_ACCEPT, 0, 0, 0);
    send_request(culw_pkg::REQ_RESTORE, top - 1, top, 0);     // snapshot near wrap
    send_request(culw_pkg::REQ_STABLE, top - 1, 0, 0);        // snapshot matched
    send_request(culw_pkg::REQ_QUERY, top - 1, 0, 0);
    send_request(culw_pkg::REQ_APPEND, top, 64'd7, 32'hA5A5);
    send_request(culw_pkg::REQ_STABLE, top, 64'd7, 0);        // window start wraps to zero
    send_request(culw_pkg::REQ_ACCEPT, 0, 0, 0);
    send_request(culw_pkg::REQ_SNAP_OK, 3, 0, 0);             // missing
    send_request(culw_pkg::REQ_SNAP_OK, top - 1, 0, 0);
    send_request(REQ_UNDEF, top, top, 32'hFFFF_FFFF);         // undefined selector
    send_request(culw_pkg::REQ_RESTORE, 0, 0, 0);
    drain_results();
  endtask

  // Fill the window to full, then pull the whole run of 32 entries.
  task automatic test_full_window();
    logic [63:0] base;
    base = rand64();
    // empty the window so that it starts at base
    send_request(culw_pkg::REQ_RESTORE, base - 64'd1, rand64(), 0, 0);
    // the last append finds the window full
    for (int i = 0; i <= culw_pkg::WINDOW_DEPTH; i++)
      send_request(culw_pkg::REQ_APPEND, base + 64'(i), rand64(), $urandom());
    send_request(culw_pkg::REQ_NEXT, 0, 0, 0);
    send_request(culw_pkg::REQ_NEXT, 0, 0, 0);
    release_start();
    // sender pauses until every result is back
    drain_results();
  endtask

  // Random well-formed traffic around a live window, plus noise.
  task automatic test_random_traffic(int count);
    logic [63:0] ix, tm;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      ix = win_start + 64'($urandom_range(0, win_count + 1)) - 64'($urandom_range(0, 1));
      tm = (win_count > 0 && ix >= win_start && ix - win_start < 64'(win_count)
            && $urandom_range(0, 3) != 0) ? term_ring[ix % culw_pkg::WINDOW_DEPTH]
                                           : rand64();
      if (pick < 8) ix = rand64();
      if (pick < 40)
        send_request(culw_pkg::REQ_APPEND, (pick < 30) ? win_start + 64'(win_count) : ix,
                     rand64(), $urandom());
      else if (pick < 50) send_request(culw_pkg::REQ_QUERY, ix, 0, 0);
      else if (pick < 62) send_request(culw_pkg::REQ_STABLE, ix, tm, 0);
      else if (pick < 68)
        send_request(culw_pkg::REQ_SNAP_OK,
                     ($urandom_range(0, 1) && snap_held) ? snap_idx : ix, 0, 0);
      else if (pick < 73)
        send_request(culw_pkg::REQ_RESTORE, $urandom_range(0, 1) ? rand64() : ix,
                     rand64(), 0);
      else if (pick < 82)
        send_request(culw_pkg::REQ_ACCEPT, rand64(), rand64(), $urandom());
      else if (pick < 97)
        send_request(culw_pkg::REQ_NEXT, rand64(), rand64(), $urandom());
      else send_request(REQ_UNDEF, rand64(), rand64(), $urandom());
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = '0;
    in_entry_index = '0;
    in_entry_term = '0;
    in_entry_handle = '0;
    win_start = '0; prog_mark = '0; win_count = 0;
    snap_held = 0; snap_idx = '0; snap_trm = '0; snap_acc = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_window();
    test_random_traffic(115);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
